[design/assert_macros.svh]
// assertion macros shared by the blackbody color pipeline
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[design/bb2rgb_pkg.sv]
// constants, coefficient tables and fixed point helpers for the
// blackbody color pipeline; no dependencies
package bb2rgb_pkg;

  localparam int FRAC = 28;
  localparam int LEVEL_FRACTION_BITS_DEF = 13;

  // temperature range and segment split points in kelvin
  localparam logic [15:0] TEMP_MIN = 16'd800;
  localparam logic [15:0] TEMP_MAX = 16'd25000;
  localparam logic [14:0] TEMP_SPLIT_LOW = 15'd2222;
  localparam logic [14:0] TEMP_SPLIT_HIGH = 15'd4000;

  // 1000.0 in Q28
  localparam logic [37:0] T_NUM = 38'd268435456000;
  localparam logic signed [33:0] ONE_Q = 34'sd268435456;
  localparam logic [61:0] LIM_Q = 62'd4294967296;

  typedef enum logic [1:0] {
    SEG_LOW,
    SEG_MID,
    SEG_HIGH
  } seg_t;

  localparam longint QS = 64'sd268435456;
  localparam longint QD = 64'sd100000000;
  localparam longint QH = 64'sd50000000;

  // decimal coefficient scaled by 1e8 into Q28, rounded half away from zero
  function automatic logic signed [31:0] qc(input longint n);
    longint r;
    r = (n * QS + ((n < 0) ? -QH : QH)) / QD;
    return r[31:0];
  endfunction

  typedef logic signed [31:0] coef_t;

  // x as a cubic in t: index 0 cubes, 3 is the constant term
  localparam coef_t XLO_C [4] = '{qc(-26612390), qc(-23435800), qc(87769560), qc(17991000)};
  localparam coef_t XHI_C [4] = '{qc(-302584690), qc(210703790), qc(22263470), qc(24039000)};
  // y as a cubic in x
  localparam coef_t YA_C [4] = '{qc(-110638140), qc(-134811020), qc(218555832), qc(-20219683)};
  localparam coef_t YB_C [4] = '{qc(-95494760), qc(-137418593), qc(209137015), qc(-16748867)};
  localparam coef_t YC_C [4] = '{qc(308175800), qc(-587338670), qc(375112997), qc(-37001483)};
  // xyz to linear srgb rows: X column, Y column (Y = 1), Z column
  localparam coef_t MAT_X [3] = '{qc(324060000), qc(-96890000), qc(5570000)};
  localparam coef_t MAT_K [3] = '{qc(-153720000), qc(187580000), qc(-20400000)};
  localparam coef_t MAT_Z [3] = '{qc(-49860000), qc(4150000), qc(105700000)};

  // Q28 product rounded half up (floor of product plus half)
  function automatic logic signed [37:0] mulq(input logic signed [31:0] a,
                                               input logic signed [33:0] b);
    logic signed [65:0] p;
    logic signed [65:0] s;
    p = a * b;
    s = (p + 66'sd134217728) >>> FRAC;
    return s[37:0];
  endfunction

endpackage

[design/bb2rgb_div.sv]
// pipelined restoring divider, one quotient bit per stage, with sideband
// depends on assert_macros.svh only; bb2rgb_pkg is not used
`include "assert_macros.svh"
module bb2rgb_div #(
  parameter int NUM_W = 38,
  parameter int DEN_W = 15,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [NUM_W-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld_r  [NUM_W];
  logic [DEN_W-1:0]  rem_r  [NUM_W];
  logic [NUM_W-1:0]  nq_r   [NUM_W];
  logic [DEN_W-1:0]  den_r  [NUM_W];
  logic [SIDE_W-1:0] side_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic              vld_p;
    logic [DEN_W-1:0]  rem_p;
    logic [NUM_W-1:0]  nq_p;
    logic [DEN_W-1:0]  den_p;
    logic [SIDE_W-1:0] side_p;
    logic [DEN_W:0]    trial;
    logic              ge;
    logic [DEN_W-1:0]  rem_nxt;
    logic [NUM_W-1:0]  nq_nxt;

    // stage input: module ports or previous stage
    if (k == 0) begin : g_first
      assign vld_p  = in_vld;
      assign rem_p  = '0;
      assign nq_p   = in_num;
      assign den_p  = in_den;
      assign side_p = in_side;
    end else begin : g_next
      assign vld_p  = vld_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign nq_p   = nq_r[k-1];
      assign den_p  = den_r[k-1];
      assign side_p = side_r[k-1];
    end

    // bring down one numerator bit, subtract if it fits
    assign trial   = {rem_p, nq_p[NUM_W-1]};
    assign ge      = trial >= {1'b0, den_p};
    assign rem_nxt = ge ? DEN_W'(trial - {1'b0, den_p}) : trial[DEN_W-1:0];
    assign nq_nxt  = {nq_p[NUM_W-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      nq_r[k]   <= nq_nxt;
      den_r[k]  <= den_p;
      side_r[k] <= side_p;
    end
  end

  assign out_vld  = vld_r[NUM_W-1];
  assign out_quo  = nq_r[NUM_W-1];
  assign out_side = side_r[NUM_W-1];

  `ASSERT_IMPLIES(a_rem_below_den, clk, rst_n, vld_r[NUM_W-1] && (den_r[NUM_W-1] != '0), rem_r[NUM_W-1] < den_r[NUM_W-1], "divider remainder not below divisor")

endmodule

[design/blackbody_temperature_to_rgb.sv]
// Throughput: one item per cycle; busy is always low, every stage is a
// fixed pipeline step, and the two long divider chains set the latency.
// Reset clears only the valid bits; payload registers are not reset.
// The receiver cannot stall, so results leave on out_valid unconditionally.
// Depends on bb2rgb_pkg, bb2rgb_div and assert_macros.svh.
`include "assert_macros.svh"
module blackbody_temperature_to_rgb #(
  parameter int LEVEL_FRACTION_BITS = bb2rgb_pkg::LEVEL_FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_temperature_kelvin,
  output logic        out_valid,
  output logic [15:0] out_red_level,
  output logic [15:0] out_green_level,
  output logic [15:0] out_blue_level,
  output logic        out_fallback_white
);

  localparam int SH = bb2rgb_pkg::FRAC - LEVEL_FRACTION_BITS;
  localparam logic [15:0] WHITE = (LEVEL_FRACTION_BITS >= 16) ? 16'hFFFF
                                  : 16'(32'd1 << LEVEL_FRACTION_BITS);
  localparam logic signed [39:0] RND = 40'sd1 <<< (SH - 1);

  function automatic logic [15:0] to_level(input logic signed [39:0] v);
    logic signed [39:0] q;
    q = (v + RND) >>> SH;
    if (v <= 0) return 16'd0;
    if (q > 40'sd65535) return 16'hFFFF;
    return q[15:0];
  endfunction

  assign busy = 1'b0;

  // stage 0: clamp and segment
  logic [14:0] temp_nxt;
  bb2rgb_pkg::seg_t seg_nxt;
  logic v0_r;
  logic [14:0] temp0_r;
  bb2rgb_pkg::seg_t seg0_r;

  always_comb begin
    if (in_temperature_kelvin < bb2rgb_pkg::TEMP_MIN) begin
      temp_nxt = bb2rgb_pkg::TEMP_MIN[14:0];
    end else if (in_temperature_kelvin > bb2rgb_pkg::TEMP_MAX) begin
      temp_nxt = bb2rgb_pkg::TEMP_MAX[14:0];
    end else begin
      temp_nxt = in_temperature_kelvin[14:0];
    end
    if (temp_nxt < bb2rgb_pkg::TEMP_SPLIT_LOW) begin
      seg_nxt = bb2rgb_pkg::SEG_LOW;
    end else if (temp_nxt < bb2rgb_pkg::TEMP_SPLIT_HIGH) begin
      seg_nxt = bb2rgb_pkg::SEG_MID;
    end else begin
      seg_nxt = bb2rgb_pkg::SEG_HIGH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    temp0_r <= temp_nxt;
    seg0_r  <= seg_nxt;
  end

  // t = 1000 / T in Q28
  logic        tq_vld;
  logic [37:0] tq;
  logic [1:0]  tq_side;

  bb2rgb_div #(.NUM_W(38), .DEN_W(15), .SIDE_W(2)) u_tdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v0_r),
    .in_num   (bb2rgb_pkg::T_NUM + 38'(temp0_r >> 1)),
    .in_den   (temp0_r),
    .in_side  (seg0_r),
    .out_vld  (tq_vld),
    .out_quo  (tq),
    .out_side (tq_side)
  );

  // stage 2: t squared
  logic signed [37:0] tsq_full;
  logic v2_r;
  logic [28:0] t2_t_r, t2_sq_r;
  bb2rgb_pkg::seg_t seg2_r;

  assign tsq_full = bb2rgb_pkg::mulq($signed({3'b0, tq[28:0]}), $signed({5'b0, tq[28:0]}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= tq_vld;
    end
  end

  always_ff @(posedge clk) begin
    t2_t_r  <= tq[28:0];
    t2_sq_r <= tsq_full[28:0];
    seg2_r  <= bb2rgb_pkg::seg_t'(tq_side);
  end

  // stage 3: t cubed
  logic signed [37:0] tcu_full;
  logic v3_r;
  logic [28:0] t3_t_r, t3_sq_r, t3_cu_r;
  bb2rgb_pkg::seg_t seg3_r;

  assign tcu_full = bb2rgb_pkg::mulq($signed({3'b0, t2_sq_r}), $signed({5'b0, t2_t_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    t3_t_r  <= t2_t_r;
    t3_sq_r <= t2_sq_r;
    t3_cu_r <= tcu_full[28:0];
    seg3_r  <= seg2_r;
  end

  // stage 4: x polynomial products
  bb2rgb_pkg::coef_t xc0, xc1, xc2, xc3;
  logic signed [37:0] xp3_full, xp2_full, xp1_full;
  logic v4_r;
  logic signed [33:0] xp3_r, xp2_r, xp1_r;
  bb2rgb_pkg::coef_t xc3_r;
  bb2rgb_pkg::seg_t seg4_r;

  always_comb begin
    unique case (seg3_r)
      bb2rgb_pkg::SEG_HIGH: begin
        xc0 = bb2rgb_pkg::XHI_C[0];
        xc1 = bb2rgb_pkg::XHI_C[1];
        xc2 = bb2rgb_pkg::XHI_C[2];
        xc3 = bb2rgb_pkg::XHI_C[3];
      end
      default: begin
        xc0 = bb2rgb_pkg::XLO_C[0];
        xc1 = bb2rgb_pkg::XLO_C[1];
        xc2 = bb2rgb_pkg::XLO_C[2];
        xc3 = bb2rgb_pkg::XLO_C[3];
      end
    endcase
  end

  assign xp3_full = bb2rgb_pkg::mulq(xc0, $signed({5'b0, t3_cu_r}));
  assign xp2_full = bb2rgb_pkg::mulq(xc1, $signed({5'b0, t3_sq_r}));
  assign xp1_full = bb2rgb_pkg::mulq(xc2, $signed({5'b0, t3_t_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    xp3_r  <= xp3_full[33:0];
    xp2_r  <= xp2_full[33:0];
    xp1_r  <= xp1_full[33:0];
    xc3_r  <= xc3;
    seg4_r <= seg3_r;
  end

  // stage 5: x sum
  logic signed [35:0] xsum;
  logic v5_r;
  logic signed [31:0] x5_r;
  bb2rgb_pkg::seg_t seg5_r;

  assign xsum = 36'(xp3_r) + 36'(xp2_r) + 36'(xp1_r) + 36'(xc3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    x5_r   <= xsum[31:0];
    seg5_r <= seg4_r;
  end

  // stage 6: x squared
  logic signed [37:0] xsq_full;
  logic v6_r;
  logic signed [31:0] x6_r, x6_sq_r;
  bb2rgb_pkg::seg_t seg6_r;

  assign xsq_full = bb2rgb_pkg::mulq(x5_r, 34'(x5_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    x6_r    <= x5_r;
    x6_sq_r <= xsq_full[31:0];
    seg6_r  <= seg5_r;
  end

  // stage 7: x cubed
  logic signed [37:0] xcu_full;
  logic v7_r;
  logic signed [31:0] x7_r, x7_sq_r, x7_cu_r;
  bb2rgb_pkg::seg_t seg7_r;

  assign xcu_full = bb2rgb_pkg::mulq(x6_sq_r, 34'(x6_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    x7_r    <= x6_r;
    x7_sq_r <= x6_sq_r;
    x7_cu_r <= xcu_full[31:0];
    seg7_r  <= seg6_r;
  end

  // stage 8: y polynomial products
  bb2rgb_pkg::coef_t yc0, yc1, yc2, yc3;
  logic signed [37:0] yp3_full, yp2_full, yp1_full;
  logic v8_r;
  logic signed [33:0] yp3_r, yp2_r, yp1_r;
  bb2rgb_pkg::coef_t yc3_r;
  logic signed [31:0] x8_r;

  always_comb begin
    unique case (seg7_r)
      bb2rgb_pkg::SEG_LOW: begin
        yc0 = bb2rgb_pkg::YA_C[0];
        yc1 = bb2rgb_pkg::YA_C[1];
        yc2 = bb2rgb_pkg::YA_C[2];
        yc3 = bb2rgb_pkg::YA_C[3];
      end
      bb2rgb_pkg::SEG_MID: begin
        yc0 = bb2rgb_pkg::YB_C[0];
        yc1 = bb2rgb_pkg::YB_C[1];
        yc2 = bb2rgb_pkg::YB_C[2];
        yc3 = bb2rgb_pkg::YB_C[3];
      end
      default: begin
        yc0 = bb2rgb_pkg::YC_C[0];
        yc1 = bb2rgb_pkg::YC_C[1];
        yc2 = bb2rgb_pkg::YC_C[2];
        yc3 = bb2rgb_pkg::YC_C[3];
      end
    endcase
  end

  assign yp3_full = bb2rgb_pkg::mulq(yc0, 34'(x7_cu_r));
  assign yp2_full = bb2rgb_pkg::mulq(yc1, 34'(x7_sq_r));
  assign yp1_full = bb2rgb_pkg::mulq(yc2, 34'(x7_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else begin
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    yp3_r <= yp3_full[33:0];
    yp2_r <= yp2_full[33:0];
    yp1_r <= yp1_full[33:0];
    yc3_r <= yc3;
    x8_r  <= x7_r;
  end

  // stage 9: y sum and fallback test
  logic signed [35:0] ysum;
  logic v9_r;
  logic signed [31:0] x9_r, y9_r;
  logic fb9_r;

  assign ysum = 36'(yp3_r) + 36'(yp2_r) + 36'(yp1_r) + 36'(yc3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else begin
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    x9_r  <= x8_r;
    y9_r  <= ysum[31:0];
    fb9_r <= ysum <= 36'sd0;
  end

  // stage 10: scaled numerators for X and Z, plus rounding half divisor
  logic signed [33:0] omx;
  logic signed [61:0] yhalf;
  logic v10_r;
  logic signed [61:0] nx10_r, nz10_r;
  logic signed [31:0] y10_r;
  logic fb10_r;

  assign omx   = bb2rgb_pkg::ONE_Q - 34'(x9_r) - 34'(y9_r);
  assign yhalf = {{31{y9_r[31]}}, y9_r[31:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
    end else begin
      v10_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    nx10_r <= $signed({{2{x9_r[31]}}, x9_r, 28'b0}) + yhalf;
    nz10_r <= $signed({omx, 28'b0}) + yhalf;
    y10_r  <= y9_r;
    fb10_r <= fb9_r;
  end

  // stage 11: magnitudes for floor division
  logic signed [61:0] yext;
  logic v11_r;
  logic [61:0] mx11_r, mz11_r;
  logic nx11_r, nz11_r, fb11_r;
  logic [31:0] y11_r;

  assign yext = 62'(y10_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v11_r <= 1'b0;
    end else begin
      v11_r <= v10_r;
    end
  end

  always_ff @(posedge clk) begin
    mx11_r <= nx10_r[61] ? 62'(-nx10_r + yext - 62'sd1) : 62'(nx10_r);
    mz11_r <= nz10_r[61] ? 62'(-nz10_r + yext - 62'sd1) : 62'(nz10_r);
    nx11_r <= nx10_r[61];
    nz11_r <= nz10_r[61];
    fb11_r <= fb10_r;
    y11_r  <= y10_r;
  end

  // X = x / y and Z = (1 - x - y) / y
  logic        xq_vld, zq_vld;
  logic [61:0] xq, zq;
  logic [1:0]  xq_side;
  logic        zq_side;

  bb2rgb_div #(.NUM_W(62), .DEN_W(32), .SIDE_W(2)) u_xdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v11_r),
    .in_num   (mx11_r),
    .in_den   (y11_r),
    .in_side  ({fb11_r, nx11_r}),
    .out_vld  (xq_vld),
    .out_quo  (xq),
    .out_side (xq_side)
  );

  bb2rgb_div #(.NUM_W(62), .DEN_W(32), .SIDE_W(1)) u_zdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v11_r),
    .in_num   (mz11_r),
    .in_den   (y11_r),
    .in_side  (nz11_r),
    .out_vld  (zq_vld),
    .out_quo  (zq),
    .out_side (zq_side)
  );

  // stage 12: sign restore and clamp to +-16
  logic [61:0] xs, zs;
  logic v12_r;
  logic signed [33:0] bx12_r, bz12_r;
  logic fb12_r;

  assign xs = (xq > bb2rgb_pkg::LIM_Q) ? bb2rgb_pkg::LIM_Q : xq;
  assign zs = (zq > bb2rgb_pkg::LIM_Q) ? bb2rgb_pkg::LIM_Q : zq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v12_r <= 1'b0;
    end else begin
      v12_r <= xq_vld;
    end
  end

  always_ff @(posedge clk) begin
    bx12_r <= xq_side[0] ? -$signed(xs[33:0]) : $signed(xs[33:0]);
    bz12_r <= zq_side ? -$signed(zs[33:0]) : $signed(zs[33:0]);
    fb12_r <= xq_side[1];
  end

  // stage 13: matrix products
  logic v13_r;
  logic signed [37:0] px13_r [3];
  logic signed [37:0] pz13_r [3];
  logic fb13_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v13_r <= 1'b0;
    end else begin
      v13_r <= v12_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      px13_r[ch] <= bb2rgb_pkg::mulq(bb2rgb_pkg::MAT_X[ch], bx12_r);
      pz13_r[ch] <= bb2rgb_pkg::mulq(bb2rgb_pkg::MAT_Z[ch], bz12_r);
    end
    fb13_r <= fb12_r;
  end

  // stage 14: channel sums
  logic v14_r;
  logic signed [39:0] ch14_r [3];
  logic fb14_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v14_r <= 1'b0;
    end else begin
      v14_r <= v13_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      ch14_r[ch] <= 40'(px13_r[ch]) + 40'(bb2rgb_pkg::MAT_K[ch]) + 40'(pz13_r[ch]);
    end
    fb14_r <= fb13_r;
  end

  // stage 15: output levels
  logic out_valid_r;
  logic [15:0] red_r, green_r, blue_r;
  logic fb_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v14_r;
    end
  end

  always_ff @(posedge clk) begin
    red_r    <= fb14_r ? WHITE : to_level(ch14_r[0]);
    green_r  <= fb14_r ? WHITE : to_level(ch14_r[1]);
    blue_r   <= fb14_r ? WHITE : to_level(ch14_r[2]);
    fb_out_r <= fb14_r;
  end

  assign out_valid          = out_valid_r;
  assign out_red_level      = red_r;
  assign out_green_level    = green_r;
  assign out_blue_level     = blue_r;
  assign out_fallback_white = fb_out_r;

  `ASSERT_ALWAYS(a_div_aligned, clk, rst_n, xq_vld == zq_vld, "X and Z dividers out of step")
  `ASSERT_IMPLIES(a_xz_clamped, clk, rst_n, v12_r, (bx12_r <= 34'sd4294967296) && (bx12_r >= -34'sd4294967296) && (bz12_r <= 34'sd4294967296) && (bz12_r >= -34'sd4294967296), "X or Z outside clamp")
  `ASSERT_IMPLIES(a_white_equal, clk, rst_n, out_valid && out_fallback_white, (out_red_level == out_green_level) && (out_green_level == out_blue_level), "fallback item not white")

endmodule
